// ===== design/rpa_pkg.sv =====
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and codes of the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

    // action codes
    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_ADDREF = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // status codes
    localparam logic [2:0] ST_ALLOC    = 3'd0;
    localparam logic [2:0] ST_OOM      = 3'd1;
    localparam logic [2:0] ST_RELEASED = 3'd2;
    localparam logic [2:0] ST_DECR     = 3'd3;
    localparam logic [2:0] ST_BAD      = 3'd4;
    localparam logic [2:0] ST_ADDED    = 3'd5;
    localparam logic [2:0] ST_OVERFLOW = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_REGION_BASE  = 2'd0;
    localparam logic [1:0] CFG_FIRST_USABLE = 2'd1;
    localparam logic [1:0] CFG_REGION_END   = 2'd2;

    localparam logic [31:0] RST_REGION_BASE  = 32'h8000_0000;
    localparam logic [31:0] RST_FIRST_USABLE = 32'h8000_0000;
    localparam logic [31:0] RST_REGION_END   = 32'h8800_0000;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] page_addr;
    } rpa_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_addr;
        logic [7:0]  count_after;
    } rpa_rsp_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_COMMIT
    } rpa_state_t;

    typedef struct packed {
        logic clear;
        logic latch;
        logic lookup;
        logic commit;
    } rpa_ctl_t;

    typedef struct packed {
        logic clear_done;
    } rpa_stat_t;

endpackage

// ===== design/refcounted_page_allocator.sv =====
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Reference-counted physical page allocator with a LIFO free-page stack.
// ----------------------------------------------------------------------------
// After reset the block sweeps the count table to zero, one entry per cycle,
// holding busy high until the sweep ends; configuration writes are taken
// during that time. A command is taken when start is high and busy is low;
// each one runs through latch, address check with the count or stack read,
// and write-back, as the registered read of the count and stack RAMs comes
// ahead of the read-modify-write. The result beat appears on rsp with done
// high for exactly one cycle; the receiver cannot stall it, so capture it
// then. A new command may be started in the same cycle that done is high.
module refcounted_page_allocator #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12,
    parameter int COUNT_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rpa_pkg::rpa_cmd_t cmd,
    output logic              busy,
    output logic              done,
    output rpa_pkg::rpa_rsp_t rsp,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_idx,
    input  logic [31:0]       cfg_wdata
);
    import rpa_pkg::*;

    rpa_ctl_t  ctl;
    rpa_stat_t stat;

    rpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl),
        .stat  (stat)
    );

    rpa_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .cmd       (cmd),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// ===== design/rpa_ram.sv =====
// ----------------------------------------------------------------------------
// rpa_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpa_ctrl
// Sequencer: count table clear after reset, then latch / lookup / commit.
// ----------------------------------------------------------------------------
module rpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output rpa_pkg::rpa_ctl_t ctl,
    input  rpa_pkg::rpa_stat_t stat
);
    import rpa_pkg::*;

    rpa_state_t state_reg, state_next;
    logic       done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clear = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                ctl.lookup = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                ctl.commit = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ===== design/rpa_dp.sv =====
// ----------------------------------------------------------------------------
// rpa_dp
// Datapath: config registers, address check, free stack, count table.
// ----------------------------------------------------------------------------
module rpa_dp #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12,
    parameter int COUNT_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rpa_pkg::rpa_ctl_t  ctl,
    output rpa_pkg::rpa_stat_t stat,
    input  rpa_pkg::rpa_cmd_t  cmd,
    output rpa_pkg::rpa_rsp_t  rsp,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [31:0]        cfg_wdata
);
    import rpa_pkg::*;

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int FC_W  = $clog2(NUM_PAGES + 1);
    localparam int EXT_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;

    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [31:0]      base_reg, first_reg, end_reg;
    logic [1:0]       act_reg;
    logic [31:0]      pa_reg;
    logic             valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [FC_W-1:0]  fc_reg, fc_next;
    logic [IDX_W-1:0] clr_reg;
    rpa_rsp_t         rsp_reg, rsp_next;

    logic [31:0]      off;
    logic [31:0]      off_pages;
    logic [IDX_W-1:0] idx;
    logic             addr_ok;

    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic                  stk_we;
    logic [IDX_W-1:0]      stk_waddr;
    logic [IDX_W-1:0]      stk_raddr;
    logic [IDX_W-1:0]      stk_rdata;
    logic [FC_W-1:0]       fc_dec;
    logic [EXT_W-1:0]      cnt_ext;
    logic [EXT_W-1:0]      dec_ext;
    logic [EXT_W-1:0]      inc_ext;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= RST_REGION_BASE;
            first_reg <= RST_FIRST_USABLE;
            end_reg   <= RST_REGION_END;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_REGION_BASE:  base_reg  <= cfg_wdata;
                CFG_FIRST_USABLE: first_reg <= cfg_wdata;
                CFG_REGION_END:   end_reg   <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // address check, all compares in parallel
    assign off       = pa_reg - base_reg;
    assign off_pages = off >> PAGE_SHIFT;
    assign idx       = off_pages[IDX_W-1:0];
    assign addr_ok   = (act_reg != ACT_NONE)
                    && (pa_reg[PAGE_SHIFT-1:0] == '0)
                    && (pa_reg >= first_reg)
                    && (pa_reg < end_reg)
                    && (pa_reg >= base_reg)
                    && (off[PAGE_SHIFT-1:0] == '0)
                    && (off_pages < 32'(NUM_PAGES));

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            act_reg <= cmd.action;
            pa_reg  <= cmd.page_addr;
        end
        if (ctl.lookup)
        begin
            valid_reg <= addr_ok;
            idx_reg   <= idx;
        end
        if (ctl.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg  <= '0;
            clr_reg <= '0;
        end
        else
        begin
            fc_reg <= fc_next;
            if (ctl.clear)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
        end
    end

    assign stat.clear_done = (clr_reg == IDX_W'(NUM_PAGES - 1));

    assign fc_dec    = fc_reg - FC_W'(1);
    assign stk_raddr = fc_dec[IDX_W-1:0];
    assign stk_waddr = fc_reg[IDX_W-1:0];
    assign cnt_ext   = EXT_W'(cnt_rdata);
    assign dec_ext   = EXT_W'(cnt_rdata - CNT_ONE);
    assign inc_ext   = EXT_W'(cnt_rdata + CNT_ONE);

    always_comb
    begin
        fc_next   = fc_reg;
        cnt_we    = 1'b0;
        cnt_waddr = idx_reg;
        cnt_wdata = '0;
        stk_we    = 1'b0;
        rsp_next  = '{status: ST_BAD, result_addr: 32'd0, count_after: 8'd0};

        if (ctl.clear)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_reg;
        end
        else if (ctl.commit)
        begin
            if (act_reg == ACT_ALLOC)
            begin
                if (fc_reg == '0)
                begin
                    rsp_next.status = ST_OOM;
                end
                else
                begin
                    // pop: top of stack gets its first reference
                    fc_next              = fc_dec;
                    cnt_we               = 1'b1;
                    cnt_waddr            = stk_rdata;
                    cnt_wdata            = CNT_ONE;
                    rsp_next.status      = ST_ALLOC;
                    rsp_next.result_addr = base_reg + (32'(stk_rdata) << PAGE_SHIFT);
                    rsp_next.count_after = 8'd1;
                end
            end
            else if (!valid_reg)
            begin
                rsp_next.status = ST_BAD;
            end
            else if (act_reg == ACT_FREE)
            begin
                if (cnt_rdata > CNT_ONE)
                begin
                    cnt_we               = 1'b1;
                    cnt_wdata            = cnt_rdata - CNT_ONE;
                    rsp_next.status      = ST_DECR;
                    rsp_next.count_after = dec_ext[7:0];
                end
                else if (fc_reg >= FC_W'(NUM_PAGES))
                begin
                    // stack full: report and drop
                    rsp_next.status      = ST_BAD;
                    rsp_next.count_after = cnt_ext[7:0];
                end
                else
                begin
                    stk_we          = 1'b1;
                    fc_next         = fc_reg + FC_W'(1);
                    cnt_we          = 1'b1;
                    cnt_wdata       = '0;
                    rsp_next.status = ST_RELEASED;
                end
            end
            else
            begin
                if (cnt_rdata == CNT_MAX)
                begin
                    rsp_next.status      = ST_OVERFLOW;
                    rsp_next.count_after = cnt_ext[7:0];
                end
                else
                begin
                    cnt_we               = 1'b1;
                    cnt_wdata            = cnt_rdata + CNT_ONE;
                    rsp_next.status      = ST_ADDED;
                    rsp_next.count_after = inc_ext[7:0];
                end
            end
        end
    end

    rpa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_PAGES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (idx),
        .rdata (cnt_rdata)
    );

    rpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (idx_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign rsp = rsp_reg;

endmodule
